### rtl/cls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_pkg
// Shared types, codes and constants of the frame classifier and flow counter.
// ----------------------------------------------------------------------------
package cls_pkg;

    // default flow table depth
    localparam int FLOW_ENTRIES_DEF = 1024;

    // header codes
    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [15:0] ETH_IPV6   = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_ICMP6 = 8'd58;
    localparam logic [15:0] POS_ETH_HI = 16'd12;
    localparam logic [15:0] POS_ETH_LO = 16'd13;
    localparam logic [15:0] POS_IHL    = 16'd14;
    localparam logic [15:0] POS_NH6    = 16'd20;
    localparam logic [15:0] POS_PROTO4 = 16'd23;
    localparam logic [15:0] POS_IP_LO  = 16'd26;
    localparam logic [15:0] POS_IP_HI  = 16'd33;
    localparam logic [15:0] POS_MAX    = 16'hFFFF;

    // packet class codes
    typedef enum logic [3:0] {
        PC_OTHER  = 4'd0,
        PC_V4_TCP = 4'd1,
        PC_V4_UDP = 4'd2,
        PC_V4_ICMP = 4'd3,
        PC_V4_OTH = 4'd4,
        PC_V6_TCP = 4'd5,
        PC_V6_UDP = 4'd6,
        PC_V6_ICMP = 4'd7,
        PC_V6_OTH = 4'd8
    } t_pclass;

    // flow status codes
    typedef enum logic [1:0] {
        FS_NONE = 2'd0,
        FS_HIT  = 2'd1,
        FS_NEW  = 2'd2,
        FS_FULL = 2'd3
    } t_fstat;

    // flow table entry: addresses, ports and protocol, packets, bytes
    localparam int ENTRY_W = 64 + 40 + 32 + 48;

    // controller to datapath commands
    typedef struct packed {
        logic take;      // parse the accepted byte
        logic rd_first;  // read entry zero
        logic rd_next;   // read following entry
        logic wr_hit;    // update matched entry
        logic wr_new;    // store new entry
        logic set_full;  // mark table full
        logic finish;    // load result, bump counters, clear header
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic tracked;   // ipv4 tcp or udp
        logic used_zero;
        logic match;
        logic last;      // current entry is the last used one
        logic full;
        logic out_free;
    } t_stat;

endpackage

### rtl/cls_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_in_if / cls_out_if
// Valid-ready channels for frame bytes and per-frame results.
// ----------------------------------------------------------------------------
interface cls_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [15:0] wire_length;
    modport source (output valid, frame_byte, last_byte, wire_length, input ready);
    modport sink   (input valid, frame_byte, last_byte, wire_length, output ready);
endinterface

interface cls_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  packet_class;
    logic [1:0]  flow_status;
    logic [9:0]  flow_slot;
    logic [31:0] flow_packet_total;
    logic [47:0] flow_byte_total;
    logic [31:0] total_frames;
    logic [31:0] ipv4_frames;
    logic [31:0] ipv6_frames;
    logic [31:0] tcp_frames;
    logic [31:0] udp_frames;
    logic [31:0] icmp_frames;
    logic        limit_reached;
    modport source (output valid, packet_class, flow_status, flow_slot, flow_packet_total,
                    flow_byte_total, total_frames, ipv4_frames, ipv6_frames, tcp_frames,
                    udp_frames, icmp_frames, limit_reached, input ready);
    modport sink   (input valid, packet_class, flow_status, flow_slot, flow_packet_total,
                    flow_byte_total, total_frames, ipv4_frames, ipv6_frames, tcp_frames,
                    udp_frames, icmp_frames, limit_reached, output ready);
endinterface

### rtl/cls_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module cls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/cls_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_ctrl
// Controller: byte intake, classification and linear flow table search.
// ----------------------------------------------------------------------------
module cls_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  cls_pkg::t_stat i_stat,
    output cls_pkg::t_cmd  o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLASS = 6'b000010,
        S_CMP   = 6'b000100,
        S_MISS  = 6'b001000,
        S_DONE  = 6'b010000,
        S_SPARE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_in_last) begin
                        n_state = S_CLASS;
                    end
                end
            end
            S_CLASS: begin
                if (!i_stat.tracked) begin
                    n_state = S_DONE;
                end else if (i_stat.used_zero) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.rd_first = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.match) begin
                    o_cmd.wr_hit = 1'b1;
                    n_state = S_DONE;
                end else if (!i_stat.last) begin
                    o_cmd.rd_next = 1'b1;
                end else begin
                    n_state = S_MISS;
                end
            end
            S_MISS: begin
                if (i_stat.full) begin
                    o_cmd.set_full = 1'b1;
                end else begin
                    o_cmd.wr_new = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

### rtl/cls_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cls_dpath
// Datapath: header parser, class counters, flow table and result register.
// ----------------------------------------------------------------------------
module cls_dpath #(
    parameter int FLOW_ENTRIES = cls_pkg::FLOW_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [31:0]    i_cfg_wr_data,
    input  cls_pkg::t_cmd  i_cmd,
    output cls_pkg::t_stat o_stat,
    cls_in_if.sink         i_in,
    cls_out_if.source      o_out
);
    localparam int IDX_W = $clog2(FLOW_ENTRIES);
    localparam int UW    = $clog2(FLOW_ENTRIES + 1);

    // header state
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_eth, n_eth;
    logic [7:0]  r_proto4, n_proto4;
    logic [7:0]  r_nh6, n_nh6;
    logic [31:0] r_ports, n_ports;
    logic [63:0] r_ips, n_ips;
    logic [5:0]  r_ihb, n_ihb;
    logic [15:0] r_wlen;
    logic [31:0] r_limit;

    // flow table state
    logic [UW-1:0]    r_used;
    logic [IDX_W-1:0] r_idx, rd_addr, wr_addr;
    logic [cls_pkg::ENTRY_W-1:0] rd_data, wr_data;
    logic [63:0] e_ips;
    logic [39:0] e_key;
    logic [31:0] e_pk;
    logic [47:0] e_by;

    // counters and flow result
    logic [31:0] r_total, r_v4, r_v6, r_tcp, r_udp, r_icmp;
    cls_pkg::t_fstat  r_fstat;
    logic [IDX_W-1:0] r_fslot;
    logic [31:0] r_fpk;
    logic [47:0] r_fby;
    cls_pkg::t_pclass pclass;
    logic [31:0] total_n;
    logic [31:0] slot_ext;
    logic        r_ovalid;

    // parser
    logic [15:0] q;
    logic [15:0] ip_off, pt_off;
    logic [7:0]  b;
    always_comb begin
        b        = i_in.frame_byte;
        n_pos    = r_pos;
        n_eth    = r_eth;
        n_proto4 = r_proto4;
        n_nh6    = r_nh6;
        n_ports  = r_ports;
        n_ips    = r_ips;
        n_ihb    = r_ihb;
        ip_off   = r_pos - cls_pkg::POS_IP_LO;
        if (i_cmd.take && r_pos == cls_pkg::POS_IHL) begin
            n_ihb = {b[3:0], 2'b00};
        end
        q      = cls_pkg::POS_IHL + 16'(n_ihb);
        pt_off = r_pos - q;
        if (i_cmd.finish) begin
            n_pos = '0; n_eth = '0; n_proto4 = '0; n_nh6 = '0;
            n_ports = '0; n_ips = '0; n_ihb = '0;
        end else if (i_cmd.take && r_pos != cls_pkg::POS_MAX) begin
            n_pos = r_pos + 16'd1;
            if (r_pos == cls_pkg::POS_ETH_HI) n_eth[15:8] = b;
            if (r_pos == cls_pkg::POS_ETH_LO) n_eth[7:0] = b;
            if (r_pos == cls_pkg::POS_NH6) n_nh6 = b;
            if (r_pos == cls_pkg::POS_PROTO4) n_proto4 = b;
            if (r_pos >= cls_pkg::POS_IP_LO && r_pos <= cls_pkg::POS_IP_HI) begin
                n_ips[(3'd7 - ip_off[2:0]) * 8 +: 8] = b;
            end
            if (r_pos >= q && r_pos <= q + 16'd3) begin
                n_ports[(2'd3 - pt_off[1:0]) * 8 +: 8] = b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_eth <= '0; r_proto4 <= '0; r_nh6 <= '0;
            r_ports <= '0; r_ips <= '0; r_ihb <= '0;
        end else begin
            r_pos <= n_pos; r_eth <= n_eth; r_proto4 <= n_proto4; r_nh6 <= n_nh6;
            r_ports <= n_ports; r_ips <= n_ips; r_ihb <= n_ihb;
        end
    end

    // wire length and limit register
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_in.last_byte) begin
            r_wlen <= i_in.wire_length;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    // classification
    always_comb begin
        pclass = cls_pkg::PC_OTHER;
        if (r_eth == cls_pkg::ETH_IPV4) begin
            priority if (r_proto4 == cls_pkg::PROTO_TCP) pclass = cls_pkg::PC_V4_TCP;
            else if (r_proto4 == cls_pkg::PROTO_UDP) pclass = cls_pkg::PC_V4_UDP;
            else if (r_proto4 == cls_pkg::PROTO_ICMP) pclass = cls_pkg::PC_V4_ICMP;
            else pclass = cls_pkg::PC_V4_OTH;
        end else if (r_eth == cls_pkg::ETH_IPV6) begin
            priority if (r_nh6 == cls_pkg::PROTO_TCP) pclass = cls_pkg::PC_V6_TCP;
            else if (r_nh6 == cls_pkg::PROTO_UDP) pclass = cls_pkg::PC_V6_UDP;
            else if (r_nh6 == cls_pkg::PROTO_ICMP6) pclass = cls_pkg::PC_V6_ICMP;
            else pclass = cls_pkg::PC_V6_OTH;
        end
    end

    // flow table
    assign rd_addr = i_cmd.rd_first ? '0 : r_idx + IDX_W'(1);
    assign wr_addr = i_cmd.wr_hit ? r_idx : r_used[IDX_W-1:0];
    assign {e_ips, e_key, e_pk, e_by} = rd_data;
    always_comb begin
        if (i_cmd.wr_hit) begin
            wr_data = {e_ips, e_key, e_pk + 32'd1, e_by + 48'(r_wlen)};
        end else begin
            wr_data = {r_ips, r_ports, r_proto4, 32'd1, 48'(r_wlen)};
        end
    end

    cls_ram #(.WIDTH(cls_pkg::ENTRY_W), .DEPTH(FLOW_ENTRIES)) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_hit | i_cmd.wr_new),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_first || i_cmd.rd_next) begin
            r_idx <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.wr_new) begin
            r_used <= r_used + UW'(1);
        end
    end

    // flow result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fstat <= cls_pkg::FS_NONE;
        end else if (i_cmd.wr_hit) begin
            r_fstat <= cls_pkg::FS_HIT;
        end else if (i_cmd.wr_new) begin
            r_fstat <= cls_pkg::FS_NEW;
        end else if (i_cmd.set_full) begin
            r_fstat <= cls_pkg::FS_FULL;
        end else if (i_cmd.finish) begin
            r_fstat <= cls_pkg::FS_NONE;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fslot <= '0;
            r_fpk   <= '0;
            r_fby   <= '0;
        end else if (i_cmd.wr_hit || i_cmd.wr_new) begin
            r_fslot <= wr_addr;
            r_fpk   <= wr_data[79:48];
            r_fby   <= wr_data[47:0];
        end else if (i_cmd.finish || i_cmd.set_full) begin
            r_fslot <= '0;
            r_fpk   <= '0;
            r_fby   <= '0;
        end
    end

    assign o_stat.tracked   = (pclass == cls_pkg::PC_V4_TCP) || (pclass == cls_pkg::PC_V4_UDP);
    assign o_stat.used_zero = (r_used == '0);
    assign o_stat.match     = (e_ips == r_ips) && (e_key == {r_ports, r_proto4});
    assign o_stat.last      = (UW'(r_idx) + UW'(1) >= r_used);
    assign o_stat.full      = (r_used == UW'(FLOW_ENTRIES));
    assign o_stat.out_free  = !r_ovalid || o_out.ready;

    // class counters and result register
    assign total_n = r_total + 32'd1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0; r_v4 <= '0; r_v6 <= '0;
            r_tcp <= '0; r_udp <= '0; r_icmp <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_ovalid <= 1'b1;
                r_total  <= total_n;
                if (r_eth == cls_pkg::ETH_IPV4) r_v4 <= r_v4 + 32'd1;
                if (r_eth == cls_pkg::ETH_IPV6) r_v6 <= r_v6 + 32'd1;
                if (pclass == cls_pkg::PC_V4_TCP || pclass == cls_pkg::PC_V6_TCP)
                    r_tcp <= r_tcp + 32'd1;
                if (pclass == cls_pkg::PC_V4_UDP || pclass == cls_pkg::PC_V6_UDP)
                    r_udp <= r_udp + 32'd1;
                if (pclass == cls_pkg::PC_V4_ICMP || pclass == cls_pkg::PC_V6_ICMP)
                    r_icmp <= r_icmp + 32'd1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_out.packet_class      <= pclass;
            o_out.flow_status       <= r_fstat;
            o_out.flow_slot         <= slot_ext[9:0];
            o_out.flow_packet_total <= r_fpk;
            o_out.flow_byte_total   <= r_fby;
            o_out.limit_reached     <= (r_limit != '0) && (total_n >= r_limit);
        end
    end

    assign slot_ext            = 32'(r_fslot);
    assign o_out.valid         = r_ovalid;
    assign o_out.total_frames  = r_total;
    assign o_out.ipv4_frames   = r_v4;
    assign o_out.ipv6_frames   = r_v6;
    assign o_out.tcp_frames    = r_tcp;
    assign o_out.udp_frames    = r_udp;
    assign o_out.icmp_frames   = r_icmp;
endmodule

### rtl/packet_classifier_flow_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_classifier_flow_counter
// Frame header classifier with class counters and a 5-tuple flow table.
// ----------------------------------------------------------------------------
// channel   direction  transaction
// i_in      in         one frame byte, last mark, wire length
// o_out     out        one result per frame: class, flow result, counters
// i_cfg     in         packet limit write
//
// one byte a cycle while no frame end is being processed
// a frame end passes a classify step, then for tracked frames a search of the used
// flow entries (up to FLOW_ENTRIES) and a miss step when none matches, then done
// the search walks the flow table RAM one read port entry a cycle
// results wait in an output register; the next frame's bytes are taken meanwhile
// synchronous reset clears counters and table fill count, no clearing pass
// ----------------------------------------------------------------------------
module packet_classifier_flow_counter #(
    parameter int FLOW_ENTRIES = cls_pkg::FLOW_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    cls_in_if.sink      i_in,
    cls_out_if.source   o_out
);
    cls_pkg::t_cmd  cmd;
    cls_pkg::t_stat stat;

    // controller
    cls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last_byte),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    cls_dpath #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_in          (i_in),
        .o_out         (o_out)
    );
endmodule
